// ===== rtl/lrm_pkg.sv =====
package lrm_pkg;

   // Window and line limits
   localparam int PATTERN_MAX = 32;
   localparam int LINE_MAX    = 767;
   localparam int LINE_CNT_W  = $clog2(LINE_MAX + 1);
   localparam int PAT_LEN_W   = 6;
   localparam int PAT_BITS    = PATTERN_MAX * 8;

   // Special bytes
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_NUL = 8'h00;

   // Item modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_BYTE  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // Search status codes
   localparam logic [1:0] ST_WAIT    = 2'd0;
   localparam logic [1:0] ST_FOUND   = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // Register indexes (byte address 8*i)
   localparam logic [2:0] REG_PAT_LEN = 3'd0;
   localparam logic [2:0] REG_PAT_0   = 3'd1;
   localparam logic [2:0] REG_PAT_1   = 3'd2;
   localparam logic [2:0] REG_PAT_2   = 3'd3;
   localparam logic [2:0] REG_PAT_3   = 3'd4;
   localparam logic [2:0] REG_TIMEOUT = 3'd5;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       line_done;
   } rsp_type;

   typedef struct packed {
      logic [PAT_LEN_W-1:0] pattern_length;
      logic [PAT_BITS-1:0]  pattern;
      logic [15:0]          timeout_ms;
   } cfg_type;

endpackage

// ===== rtl/lrm_cell.sv =====
module lrm_cell
   import lrm_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   input  logic [7:0] pat_byte,
   output logic [7:0] byte_out,
   output logic       match
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // Take the neighbor's byte on each beat that has shift_en set
   assign data_in = shift_en ? byte_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Compare the byte this cell holds after the shift
   assign match    = (byte_in == pat_byte);
   assign byte_out = data_ff;

endmodule

// ===== rtl/lrm_csr.sv =====
module lrm_csr
   import lrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [PAT_LEN_W-1:0] pat_len_ff, pat_len_in;
   logic [PAT_BITS-1:0]  pattern_ff, pattern_in;
   logic [15:0]          timeout_ff, timeout_in;
   logic                 wr_en;
   logic [2:0]           reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign wr_en   = psel & penable & pwrite & pready;

   // Decode the write beat
   always_comb begin
      pat_len_in = pat_len_ff;
      pattern_in = pattern_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PAT_LEN: pat_len_in = pwdata[PAT_LEN_W-1:0];
            REG_PAT_0:   pattern_in[0*64 +: 64] = pwdata;
            REG_PAT_1:   pattern_in[1*64 +: 64] = pwdata;
            REG_PAT_2:   pattern_in[2*64 +: 64] = pwdata;
            REG_PAT_3:   pattern_in[3*64 +: 64] = pwdata;
            REG_TIMEOUT: timeout_in = pwdata[15:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= '0;
         pattern_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         pat_len_ff <= pat_len_in;
         pattern_ff <= pattern_in;
         timeout_ff <= timeout_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_PAT_LEN: prdata = {{(64-PAT_LEN_W){1'b0}}, pat_len_ff};
         REG_PAT_0:   prdata = pattern_ff[0*64 +: 64];
         REG_PAT_1:   prdata = pattern_ff[1*64 +: 64];
         REG_PAT_2:   prdata = pattern_ff[2*64 +: 64];
         REG_PAT_3:   prdata = pattern_ff[3*64 +: 64];
         REG_TIMEOUT: prdata = {48'd0, timeout_ff};
         default:     prdata = '0;
      endcase
   end

   assign cfg.pattern_length = pat_len_ff;
   assign cfg.pattern        = pattern_ff;
   assign cfg.timeout_ms     = timeout_ff;

endmodule

// ===== rtl/line_response_matcher_top.sv =====
// Each response is registered the cycle after its request beat is accepted.
// Throughput: one request per cycle while rsp_ready is high; a new beat is
// taken while the response register drains.
// Reset: synchronous, clears search state and status to waiting, pattern to
// empty and timeout to 500 ms; no clearing pass is needed.
module line_response_matcher_top
   import lrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   cfg_type cfg;

   logic [LINE_CNT_W-1:0] line_cnt_ff, line_cnt_in;
   logic                  hit_ff, hit_in;
   logic                  nul_ff, nul_in;
   logic [15:0]           elapsed_ff, elapsed_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  active;
   logic                  shift_en;
   logic [PAT_LEN_W-1:0]  pat_n;
   logic [PAT_LEN_W-1:0]  shift_amt;
   logic [PAT_BITS-1:0]   pat_rev;
   logic [PAT_BITS-1:0]   pat_aligned;
   logic [7:0]            chain [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0] cell_eq;
   logic [PATTERN_MAX-1:0] cell_used;
   logic                  win_ok;
   logic [LINE_CNT_W-1:0] cnt_next;
   logic                  nul_next;
   logic                  line_end;

   lrm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake: the response register frees as it drains
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign active    = (status_ff == ST_WAIT) && (elapsed_ff < cfg.timeout_ms);
   assign shift_en  = accept && (req_data.mode == MODE_BYTE) && active;

   // Clamp the pattern length
   assign pat_n = (cfg.pattern_length > PAT_LEN_W'(PATTERN_MAX)) ?
                  PAT_LEN_W'(PATTERN_MAX) : cfg.pattern_length;

   // Right-justify the reversed pattern so cell k sees pattern byte n-1-k
   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pat_rev[j*8 +: 8] = cfg.pattern[(PATTERN_MAX-1-j)*8 +: 8];
      end
   end
   assign shift_amt   = PAT_LEN_W'(PATTERN_MAX) - pat_n;
   assign pat_aligned = pat_rev >> {shift_amt, 3'b000};

   // Byte cell chain, cell 0 newest
   assign chain[0] = req_data.rx_byte;
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      lrm_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (chain[k]),
         .pat_byte (pat_aligned[k*8 +: 8]),
         .byte_out (chain[k+1]),
         .match    (cell_eq[k])
      );
      assign cell_used[k] = PAT_LEN_W'(k) < pat_n;
   end

   assign win_ok   = &(cell_eq | ~cell_used);
   assign cnt_next = line_cnt_ff + 1'b1;
   assign nul_next = nul_ff | (req_data.rx_byte == BYTE_NUL);
   assign line_end = (req_data.rx_byte == BYTE_CR) ||
                     (cnt_next >= LINE_CNT_W'(LINE_MAX));

   // Advance the search on each request beat
   always_comb begin
      line_cnt_in  = line_cnt_ff;
      hit_in       = hit_ff;
      nul_in       = nul_ff;
      elapsed_in   = elapsed_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_data_in.line_done = 1'b0;
         case (req_data.mode)
            MODE_START: begin
               line_cnt_in = '0;
               hit_in      = 1'b0;
               nul_in      = 1'b0;
               elapsed_in  = '0;
               status_in   = ST_WAIT;
            end
            MODE_BYTE: begin
               if (active) begin
                  line_cnt_in = cnt_next;
                  nul_in      = nul_next;
                  hit_in      = hit_ff | (~nul_next && (pat_n != '0) &&
                                (cnt_next >= LINE_CNT_W'(pat_n)) && win_ok);
                  if (line_end) begin
                     rsp_data_in.line_done = 1'b1;
                     if (hit_in || (pat_n == '0)) begin
                        status_in = ST_FOUND;
                     end else begin
                        line_cnt_in = '0;
                        hit_in      = 1'b0;
                        nul_in      = 1'b0;
                     end
                  end
               end
            end
            MODE_TICK: begin
               if (active && (elapsed_ff != 16'hFFFF)) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            default: ;
         endcase
         // Time out a waiting search
         if ((status_in == ST_WAIT) && (elapsed_in >= cfg.timeout_ms)) begin
            status_in = ST_TIMEOUT;
         end
         rsp_data_in.status = status_in;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cnt_ff  <= '0;
         hit_ff       <= 1'b0;
         nul_ff       <= 1'b0;
         elapsed_ff   <= '0;
         status_ff    <= ST_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_cnt_ff  <= line_cnt_in;
         hit_ff       <= hit_in;
         nul_ff       <= nul_in;
         elapsed_ff   <= elapsed_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/line_response_matcher_top_test.sv =====
module line_response_matcher_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lrm_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   // Shadow of the register file
   logic [5:0]  cfg_len;
   logic [63:0] cfg_pat [4];
   logic [15:0] cfg_timeout;

   // Shadow of the search state
   logic [7:0]  line_tail [PATTERN_MAX];
   logic [9:0]  line_len;
   bit          line_hit;
   bit          line_nul;
   logic [15:0] elapsed;
   logic [1:0]  search_status;

   rsp_type     pending_rsp [$];
   logic [7:0]  pat_text [PATTERN_MAX];
   int          live_items = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          src_idle_pct = 0;
   int          dst_stall_pct = 0;

   line_response_matcher_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_response_matcher_top test failed");
         $finish;
      end
   end

   // Stall the response side at the phase rate
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= dst_stall_pct);

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic void clear_line();
      for (int i = 0; i < PATTERN_MAX; i++) line_tail[i] = 8'h00;
      line_len = '0;
      line_hit = 1'b0;
      line_nul = 1'b0;
   endfunction

   function automatic void reset_matcher();
      cfg_len = '0;
      for (int i = 0; i < 4; i++) cfg_pat[i] = '0;
      cfg_timeout = TIMEOUT_RESET;
      clear_line();
      elapsed = '0;
      search_status = ST_WAIT;
   endfunction

   // Advance the search by one request beat and return the response it causes
   function automatic rsp_type advance_matcher(input req_type item);
      rsp_type r;
      int      n;
      bit      hit;
      r.status = ST_WAIT;
      r.line_done = 1'b0;
      n = (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
      if (item.mode == MODE_START) begin
         clear_line();
         elapsed = '0;
         search_status = ST_WAIT;
         live_items++;
      end else if (search_status == ST_WAIT && elapsed < cfg_timeout) begin
         if (item.mode == MODE_BYTE) begin
            live_items++;
            for (int i = PATTERN_MAX - 1; i > 0; i--) line_tail[i] = line_tail[i-1];
            line_tail[0] = item.rx_byte;
            line_len++;
            if (item.rx_byte == BYTE_NUL) line_nul = 1'b1;
            // window compare, newest byte closes the pattern
            hit = (n != 0) && (line_len >= n) && !line_nul;
            for (int i = 0; i < n; i++)
               if (line_tail[n-1-i] != cfg_pat[i/8][(i%8)*8 +: 8]) hit = 1'b0;
            if (hit) line_hit = 1'b1;
            if (item.rx_byte == BYTE_CR || line_len >= LINE_MAX) begin
               r.line_done = 1'b1;
               if (line_hit || n == 0) search_status = ST_FOUND;
               else clear_line();
            end
         end else if (item.mode == MODE_TICK) begin
            live_items++;
            if (elapsed != 16'hFFFF) elapsed++;
         end
      end
      if (search_status == ST_WAIT && elapsed >= cfg_timeout) search_status = ST_TIMEOUT;
      r.status = search_status;
      return r;
   endfunction

   // Check response beats against the oldest prediction, then predict new request beats
   always @(posedge clock) begin : rsp_score
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch($sformatf("response status %0d line_done %0d unexpected",
                                         rsp_data.status, rsp_data.line_done));
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.line_done !== want.line_done)
                  report_mismatch($sformatf("line_done %0d, want %0d",
                                            rsp_data.line_done, want.line_done));
            end
         end
         if (req_valid && req_ready) pending_rsp.push_back(advance_matcher(req_data));
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [7:0] value);
      req_type item;
      item.mode = mode;
      item.rx_byte = value;
      @(negedge clock);
      // idle the sender at the phase rate
      if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_item(MODE_BYTE, s[i]);
      send_item(MODE_BYTE, BYTE_CR);
   endtask

   task automatic send_pattern(input int first, input int count);
      for (int k = first; k < first + count; k++) send_item(MODE_BYTE, pat_text[k]);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      drain_responses();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_PAT_LEN: cfg_len = value[5:0];
         REG_PAT_0:   cfg_pat[0] = value;
         REG_PAT_1:   cfg_pat[1] = value;
         REG_PAT_2:   cfg_pat[2] = value;
         REG_PAT_3:   cfg_pat[3] = value;
         REG_TIMEOUT: cfg_timeout = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_register(input logic [2:0] idx);
      logic [63:0] want;
      case (idx)
         REG_PAT_LEN: want = 64'(cfg_len);
         REG_PAT_0:   want = cfg_pat[0];
         REG_PAT_1:   want = cfg_pat[1];
         REG_PAT_2:   want = cfg_pat[2];
         REG_PAT_3:   want = cfg_pat[3];
         default:     want = 64'(cfg_timeout);
      endcase
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 3'b000};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want)
         report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_pattern_regs(input int len);
      logic [63:0] word [4];
      for (int k = 0; k < PATTERN_MAX; k++) word[k/8][(k%8)*8 +: 8] = pat_text[k];
      csr_write(REG_PAT_LEN, 64'(len));
      csr_write(REG_PAT_0, word[0]);
      csr_write(REG_PAT_1, word[1]);
      csr_write(REG_PAT_2, word[2]);
      csr_write(REG_PAT_3, word[3]);
   endtask

   task automatic use_pattern(input string s);
      for (int k = 0; k < PATTERN_MAX; k++) pat_text[k] = (k < s.len()) ? s[k] : 8'h00;
      write_pattern_regs(s.len());
   endtask

   // Reset values, both extremes and a mixed value on every register
   task automatic test_register_access();
      for (int i = 0; i <= 5; i++) check_register(3'(i));
      for (int i = 0; i <= 5; i++) begin
         csr_write(3'(i), '1);
         check_register(3'(i));
         csr_write(3'(i), {$urandom, $urandom});
         check_register(3'(i));
         csr_write(3'(i), '0);
         check_register(3'(i));
      end
      csr_write(REG_TIMEOUT, 64'(TIMEOUT_RESET));
   endtask

   // Empty pattern hits at the first line end, NUL or not; later beats hold found
   task automatic test_empty_pattern();
      send_item(MODE_START, 8'hFF);
      send_item(MODE_BYTE, "a");
      send_item(MODE_BYTE, BYTE_NUL);
      send_item(MODE_BYTE, BYTE_CR);
      send_item(MODE_BYTE, "b");
      send_item(MODE_BYTE, BYTE_CR);
      send_item(MODE_UNUSED, 8'hAA);
      send_item(MODE_TICK, 8'h55);
   endtask

   // Match inside a line, discarded lines and no match across a line end
   task automatic test_pattern_match();
      use_pattern("OK");
      send_item(MODE_START, 8'h00);
      send_line("xO");
      send_line("K");
      send_item(MODE_UNUSED, 8'h00);
      send_line("aOKb");
      send_item(MODE_BYTE, "z");
      // start drops a pending line
      send_item(MODE_START, 8'h00);
      send_item(MODE_BYTE, "O");
      send_item(MODE_START, 8'h00);
      send_line("K");
      send_line("OK");
   endtask

   // NUL blocks matches for the rest of its line only
   task automatic test_nul_byte();
      use_pattern("OK");
      send_item(MODE_START, 8'h00);
      send_item(MODE_BYTE, "O");
      send_item(MODE_BYTE, "K");
      send_item(MODE_BYTE, BYTE_NUL);
      send_item(MODE_BYTE, BYTE_CR);
      send_item(MODE_START, 8'h00);
      send_item(MODE_BYTE, BYTE_NUL);
      send_line("OK");
      send_line("OK");
      // a pattern holding NUL never matches
      pat_text[0] = "A";
      pat_text[1] = BYTE_NUL;
      write_pattern_regs(2);
      send_item(MODE_START, 8'h00);
      send_item(MODE_BYTE, "A");
      send_item(MODE_BYTE, BYTE_NUL);
      send_item(MODE_BYTE, BYTE_CR);
   endtask

   // Tick counting, zero timeout and a timeout lowered under a running search
   task automatic test_timeout();
      use_pattern("Z");
      csr_write(REG_TIMEOUT, 64'd3);
      send_item(MODE_START, 8'h00);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_BYTE, "Z");
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_BYTE, BYTE_CR);
      send_item(MODE_START, 8'h00);
      send_item(MODE_UNUSED, 8'h00);
      send_line("Z");
      csr_write(REG_TIMEOUT, 64'd0);
      send_item(MODE_START, 8'h00);
      send_line("Z");
      csr_write(REG_TIMEOUT, 64'd1);
      send_item(MODE_START, 8'h00);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_TICK, 8'h00);
      csr_write(REG_TIMEOUT, 64'(TIMEOUT_RESET));
      send_item(MODE_START, 8'h00);
      repeat (10) send_item(MODE_TICK, 8'h00);
      csr_write(REG_TIMEOUT, 64'd5);
      send_item(MODE_UNUSED, 8'h00);
      csr_write(REG_TIMEOUT, 64'(TIMEOUT_RESET));
   endtask

   // A line ends at the length limit without a carriage return, and the
   // pattern split across that end is not found
   task automatic test_line_limit();
      use_pattern("END");
      send_item(MODE_START, 8'h00);
      repeat (LINE_MAX - 2) send_item(MODE_BYTE, "a");
      send_item(MODE_BYTE, "E");
      send_item(MODE_BYTE, "N");
      send_item(MODE_BYTE, "D");
      send_line("");
      send_line("END");
   endtask

   // Longest pattern, a near miss, and a length register above the maximum
   task automatic test_full_pattern();
      for (int k = 0; k < PATTERN_MAX; k++) pat_text[k] = 8'($urandom_range(33, 126));
      write_pattern_regs(PATTERN_MAX);
      send_item(MODE_START, 8'h00);
      send_item(MODE_BYTE, "q");
      send_pattern(0, PATTERN_MAX);
      send_item(MODE_BYTE, BYTE_CR);
      send_item(MODE_START, 8'h00);
      send_pattern(1, PATTERN_MAX - 1);
      send_item(MODE_BYTE, BYTE_CR);
      write_pattern_regs(63);
      send_item(MODE_START, 8'h00);
      send_pattern(0, PATTERN_MAX);
      send_item(MODE_BYTE, BYTE_CR);
   endtask

   // Longest timeout holds the search open until it is lowered to the count
   task automatic test_tick_ceiling();
      csr_write(REG_TIMEOUT, 64'hFFFF);
      send_item(MODE_START, 8'h00);
      repeat (8) send_item(MODE_TICK, 8'h00);
      send_item(MODE_BYTE, BYTE_CR);
      csr_write(REG_TIMEOUT, 64'd8);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_BYTE, BYTE_CR);
      csr_write(REG_TIMEOUT, 64'(TIMEOUT_RESET));
   endtask

   task automatic configure_random_search();
      int r;
      int len;
      r = $urandom_range(9);
      len = (r == 0) ? 0 : (r == 1) ? $urandom_range(5, 32) :
            (r == 2) ? $urandom_range(33, 63) : $urandom_range(1, 4);
      if ($urandom_range(3) == 0) begin
         for (int k = 0; k < PATTERN_MAX; k++) pat_text[k] = 8'($urandom_range(255));
      end else begin
         for (int k = 0; k < PATTERN_MAX; k++)
            pat_text[k] = ($urandom_range(24) == 0) ? BYTE_NUL : 8'($urandom_range(65, 68));
      end
      write_pattern_regs(len);
      r = $urandom_range(9);
      csr_write(REG_TIMEOUT, (r == 0) ? 64'd0 : (r == 1) ? 64'hFFFF :
                64'($urandom_range(5, 60)));
   endtask

   // One filler beat: mostly pattern letters, some ticks, NULs and noise
   task automatic send_random_step(input int eff);
      int r;
      r = $urandom_range(19);
      if (r < 2)
         send_item(MODE_TICK, 8'($urandom_range(255)));
      else if (r == 2)
         send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      else if (r == 3)
         send_item(MODE_BYTE, BYTE_NUL);
      else if (eff > 0 && $urandom_range(2) != 0)
         send_item(MODE_BYTE, pat_text[$urandom_range(eff - 1)]);
      else
         send_item(MODE_BYTE, "x");
   endtask

   // Start, then a few lines of filler, some holding the whole pattern
   task automatic run_search_sequence();
      int eff;
      int fill;
      int at;
      eff = (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
      send_item(MODE_START, 8'($urandom_range(255)));
      repeat ($urandom_range(1, 3)) begin
         fill = $urandom_range(0, 10);
         at = $urandom_range(0, fill);
         for (int p = 0; p <= fill; p++) begin
            if (p == at && eff > 0 && $urandom_range(1) == 1) send_pattern(0, eff);
            send_random_step(eff);
         end
         if ($urandom_range(9) != 0) send_item(MODE_BYTE, BYTE_CR);
      end
   endtask

   task automatic test_random_traffic();
      int mark;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            1: begin src_idle_pct = 85; dst_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  dst_stall_pct = 85; end
            default: begin src_idle_pct = 30; dst_stall_pct = 30; end
         endcase
         // reconfigure twice per phase, each time after a full drain
         repeat (2) begin
            configure_random_search();
            mark = live_items;
            while (live_items - mark < 20) run_search_sequence();
         end
      end
      src_idle_pct = 0;
      dst_stall_pct = 0;
   endtask

   initial begin
      reset_matcher();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_register_access();
      test_empty_pattern();
      test_pattern_match();
      test_nul_byte();
      test_timeout();
      test_line_limit();
      test_full_pattern();
      test_tick_ceiling();
      test_random_traffic();
      drain_responses();
      repeat (4) @(negedge clock);
      if (error_count == 0)
         $display("line_response_matcher_top test passed");
      else
         $display("line_response_matcher_top test failed");
      $finish;
   end

endmodule
